[rtl/mfd_pkg.sv]
// Shared constants, types and helpers for the MFM flux bit decoder.
`default_nettype none

package mfd_pkg;

   // Sizes
   localparam int INTERVAL_BITS_DEF = 16;
   localparam int CLK_W             = 8;
   localparam int JIT_W             = 9;
   localparam int HIST_W            = 18;
   localparam int RUN_W             = 5;
   localparam int SYM_W             = 3;

   // Clock register
   localparam logic [CLK_W-1:0] CLOCK_X2_RESET = 8'd48;
   localparam logic [CLK_W-1:0] CLOCK_X2_MIN   = 8'd4;

   // Two-cell run thresholds
   localparam logic [RUN_W-1:0] RUN_SYNC = 5'd16;
   localparam logic [RUN_W-1:0] RUN_MAX  = 5'd31;

   // Sync patterns in the cell history (three bits per cell)
   localparam logic [HIST_W-1:0] SYNC_INDEX    = 18'o323434;
   localparam logic [HIST_W-1:0] SYNC_ID_LONG  = 18'o234343;
   localparam logic [14:0]       SYNC_ID_SHORT = 15'o24343;

   // Symbol codes
   localparam logic [SYM_W-1:0] SYM_ZERO  = 3'd0;
   localparam logic [SYM_W-1:0] SYM_ONE   = 3'd1;
   localparam logic [SYM_W-1:0] SYM_MZERO = 3'd2;
   localparam logic [SYM_W-1:0] SYM_RZERO = 3'd3;
   localparam logic [SYM_W-1:0] SYM_RONE  = 3'd4;
   localparam logic [SYM_W-1:0] SYM_BAD   = 3'd5;
   localparam logic [SYM_W-1:0] SYM_END   = 3'd6;

   // Control from the sequencer to the cell logic
   typedef struct packed {
      logic clear;
      logic commit;
      logic resync;
   } cell_ctrl_type;

   // One or two symbols from the cell logic
   typedef struct packed {
      logic             two_syms;
      logic [SYM_W-1:0] sym_a;
      logic [SYM_W-1:0] sym_b;
   } cell_result_type;

   // floor(n / 5) for n below 1020, by reciprocal multiply
   function automatic logic [CLK_W-1:0] div5(input logic [9:0] n);
      logic [17:0] prod;
      begin
         prod = 18'(n) * 18'd205;
         div5 = prod[17:10];
      end
   endfunction

endpackage

`default_nettype wire

[rtl/mfd_if.sv]
// Channel interfaces: flux interval in, symbol out, clock register write.
`default_nettype none

interface mfd_req_if #(
   parameter int INTERVAL_BITS = mfd_pkg::INTERVAL_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   logic [INTERVAL_BITS-1:0] interval;
   logic                     resync;
   logic                     block_start;
   logic                     end_of_flux;

   modport source (output valid, interval, resync, block_start, end_of_flux, input ready);
   modport sink   (input valid, interval, resync, block_start, end_of_flux, output ready);
endinterface

interface mfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mfd_pkg::SYM_W-1:0]     symbol;
   logic                          last;

   modport source (output valid, symbol, last, input ready);
   modport sink   (input valid, symbol, last, output ready);
endinterface

interface mfd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mfd_pkg::CLK_W-1:0]     clock_x2;

   modport source (output valid, clock_x2, input ready);
   modport sink   (input valid, clock_x2, output ready);
endinterface

`default_nettype wire

[rtl/mfd_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module mfd_serial_div #(
   parameter int DIVIDEND_BITS = mfd_pkg::INTERVAL_BITS_DEF + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DIVIDEND_BITS-1:0]       dividend,
   input  logic [mfd_pkg::CLK_W-1:0]      divisor,
   output logic                           done,
   output logic [DIVIDEND_BITS-1:0]       quotient,
   output logic [mfd_pkg::CLK_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0]  acc_ff, acc_in;
   logic [mfd_pkg::CLK_W-1:0] rem_ff, rem_in;
   logic [mfd_pkg::CLK_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [mfd_pkg::CLK_W:0]   trial;
   logic                      fits;

   // Trial subtract on the partial remainder with the next dividend bit
   assign trial = {rem_ff, acc_ff[DIVIDEND_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift in where dividend bits leave
         acc_in = {acc_ff[DIVIDEND_BITS-2:0], fits};
         rem_in = fits ? mfd_pkg::CLK_W'(trial - {1'b0, den_ff})
                       : trial[mfd_pkg::CLK_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/mfd_cell_logic.sv]
// Phase, jitter, run and sync tracking; picks the symbols for one interval.
`default_nettype none

module mfd_cell_logic #(
   parameter int QUOT_BITS = mfd_pkg::INTERVAL_BITS_DEF + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mfd_pkg::cell_ctrl_type      ctrl,
   input  logic [mfd_pkg::CLK_W-1:0]   clk_cells,
   input  logic [QUOT_BITS-1:0]        quotient,
   input  logic [mfd_pkg::CLK_W-1:0]   remainder,
   output mfd_pkg::cell_result_type    result
);

   logic                               phase_ff, phase_in;
   logic signed [mfd_pkg::JIT_W-1:0]   jit_ff, jit_in;
   logic [mfd_pkg::HIST_W-1:0]         hist_ff, hist_in;
   logic [mfd_pkg::RUN_W-1:0]          run_ff, run_in;
   logic [mfd_pkg::CLK_W-1:0]          guard_lo_ff, guard_hi_ff;

   logic                               ph1, ph2, early;
   logic [mfd_pkg::CLK_W-1:0]          guard, margin;
   logic signed [10:0]                 lhs, rhs;
   logic [QUOT_BITS-1:0]               cells;
   logic [9:0]                         err, err_mag;
   logic                               is_two, run_clear;
   logic [mfd_pkg::RUN_W-1:0]          run_inc;
   logic [2:0]                         cap;
   logic [mfd_pkg::HIST_W-1:0]         hist_new;
   logic                               sync_hit;

   // Guard bands, 3/5 and 2/5 of the clock, refreshed every cycle
   always_ff @(posedge clock) begin
      guard_hi_ff <= mfd_pkg::div5(10'(clk_cells) * 10'd3);
      guard_lo_ff <= mfd_pkg::div5(10'(clk_cells) * 10'd2);
   end

   // Early transition test and rounded cell count
   always_comb begin
      ph1    = phase_ff ^ quotient[0];
      guard  = ph1 ? guard_hi_ff : guard_lo_ff;
      margin = clk_cells - guard;
      lhs    = $signed({3'b000, remainder}) + 11'(jit_ff);
      rhs    = $signed({3'b000, margin});
      early  = lhs > rhs;
      cells  = quotient + QUOT_BITS'(early);
      ph2    = ph1 ^ early;
      // phase error, halved towards zero
      err     = early ? {2'b00, remainder} - {2'b00, clk_cells} : {2'b00, remainder};
      err_mag = ~err + 10'd1;
   end

   // Run, history and symbol choice
   always_comb begin
      phase_in = phase_ff;
      jit_in   = jit_ff;
      hist_in  = hist_ff;
      run_in   = run_ff;
      result   = '{two_syms: 1'b0, sym_a: mfd_pkg::SYM_BAD, sym_b: mfd_pkg::SYM_ZERO};

      is_two    = cells == QUOT_BITS'(2);
      run_clear = !ctrl.resync || (!is_two && (run_ff < mfd_pkg::RUN_SYNC));
      run_inc   = (run_ff == mfd_pkg::RUN_MAX) ? run_ff : run_ff + 5'd1;
      cap       = (cells < QUOT_BITS'(7)) ? cells[2:0] : 3'd7;
      hist_new  = {hist_ff[mfd_pkg::HIST_W-4:0], cap};
      sync_hit  = (hist_new == mfd_pkg::SYNC_INDEX) || (hist_new == mfd_pkg::SYNC_ID_LONG)
                  || (hist_new[14:0] == mfd_pkg::SYNC_ID_SHORT);

      jit_in = err[9] ? $signed(9'd0 - err_mag[9:1]) : $signed(err[9:1]);
      run_in = run_clear ? '0 : run_inc;

      if (!run_clear && run_inc == mfd_pkg::RUN_SYNC && !ph2) begin
         // long preamble run: force clock phase, history untouched
         phase_in     = 1'b1;
         result.sym_a = mfd_pkg::SYM_RZERO;
      end else begin
         hist_in = hist_new;
         if (sync_hit && ph2) begin
            phase_in     = 1'b0;
            result.sym_a = mfd_pkg::SYM_RONE;
         end else begin
            phase_in = ph2;
            case (cells)
               QUOT_BITS'(2): begin
                  result.sym_a = ph2 ? mfd_pkg::SYM_ZERO : mfd_pkg::SYM_ONE;
               end
               QUOT_BITS'(3): begin
                  if (ph2) begin
                     result.two_syms = 1'b1;
                     result.sym_a    = mfd_pkg::SYM_ZERO;
                     result.sym_b    = mfd_pkg::SYM_ZERO;
                  end else begin
                     result.sym_a = mfd_pkg::SYM_ONE;
                  end
               end
               QUOT_BITS'(4): begin
                  result.two_syms = 1'b1;
                  result.sym_a    = (ph2 && ctrl.resync) ? mfd_pkg::SYM_MZERO
                                                         : mfd_pkg::SYM_ZERO;
                  result.sym_b    = ph2 ? mfd_pkg::SYM_ZERO : mfd_pkg::SYM_ONE;
               end
               default: begin
                  result.sym_a = mfd_pkg::SYM_BAD;
               end
            endcase
         end
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         phase_ff <= 1'b0;
         jit_ff   <= '0;
         hist_ff  <= '0;
         run_ff   <= '0;
      end else if (ctrl.commit) begin
         phase_ff <= phase_in;
         jit_ff   <= jit_in;
         hist_ff  <= hist_in;
         run_ff   <= run_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mfm_flux_bit_decoder_core.sv]
// Top level of the MFM flux bit decoder: sequencer, held interval, symbol buffer.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------------
//  req_ch   | in  | valid / ready     | interval, resync, block_start, end_of_flux
//  rsp_ch   | out | valid / ready     | symbol, last
//  csr_ch   | in  | valid / ready     | clock_x2
//
// An interval that is divided is accepted, then yields INTERVAL_BITS + 1 quotient bits
// at one per cycle in the serial divider; the sequencer sees the divider finish and then
// commits the symbols.
// A short interval that is held is only accepted; an end item goes to the end state.
// The commit and the end symbol wait while the two-entry symbol buffer holds symbols.
// Reset is synchronous; it clears the decoder state and sets clock_x2 to 48.
`default_nettype none

module mfm_flux_bit_decoder_core #(
   parameter int INTERVAL_BITS = mfd_pkg::INTERVAL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mfd_req_if.sink     req_ch,
   mfd_rsp_if.source   rsp_ch,
   mfd_csr_if.sink     csr_ch
);

   localparam int SUM_BITS = INTERVAL_BITS + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_END  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [mfd_pkg::CLK_W-1:0]        clock_x2_ff;
   logic                             held_valid_ff, held_valid_in;
   logic [INTERVAL_BITS-1:0]         held_iv_ff, held_iv_in;
   logic                             resync_ff;
   logic [mfd_pkg::SYM_W-1:0]        sym0_ff, sym0_in, sym1_ff, sym1_in;
   logic [1:0]                       cnt_ff, cnt_in;

   logic [mfd_pkg::CLK_W-1:0]        clk_cells;
   logic                             req_take, held_live, iv_short, div_start;
   logic [SUM_BITS-1:0]              sum;
   logic                             div_done;
   logic [SUM_BITS-1:0]              quotient;
   logic [mfd_pkg::CLK_W-1:0]        remainder;
   mfd_pkg::cell_ctrl_type           cell_ctrl;
   mfd_pkg::cell_result_type         cell_res;
   logic                             pop, push_end;

   // Clock register
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_x2_ff <= mfd_pkg::CLOCK_X2_RESET;
      end else if (csr_ch.valid) begin
         clock_x2_ff <= csr_ch.clock_x2;
      end
   end

   assign clk_cells = (clock_x2_ff < mfd_pkg::CLOCK_X2_MIN) ? mfd_pkg::CLOCK_X2_MIN
                                                            : clock_x2_ff;

   // Input acceptance and held short interval
   assign req_ch.ready = state_ff == ST_IDLE;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign held_live    = held_valid_ff && !req_ch.block_start;
   assign iv_short     = req_ch.interval < INTERVAL_BITS'(clk_cells);
   assign sum          = SUM_BITS'(req_ch.interval)
                         + (held_live ? SUM_BITS'(held_iv_ff) : SUM_BITS'(0));
   assign div_start    = req_take && !req_ch.end_of_flux && (held_live || !iv_short);

   always_comb begin
      held_valid_in = held_valid_ff;
      held_iv_in    = held_iv_ff;
      if (req_take) begin
         if (req_ch.end_of_flux || div_start) begin
            held_valid_in = 1'b0;
         end else begin
            held_valid_in = 1'b1;
            held_iv_in    = req_ch.interval;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_ch.end_of_flux) begin
               state_in = ST_END;
            end else if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_FIN;
         end
         ST_FIN, ST_END: begin
            if (cnt_ff == 2'd0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
      end
      held_iv_ff <= held_iv_in;
      if (req_take) resync_ff <= req_ch.resync;
   end

   mfd_serial_div #(
      .DIVIDEND_BITS (SUM_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sum),
      .divisor   (clk_cells),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign cell_ctrl.clear  = req_take && req_ch.block_start;
   assign cell_ctrl.commit = (state_ff == ST_FIN) && (cnt_ff == 2'd0);
   assign cell_ctrl.resync = resync_ff;

   mfd_cell_logic #(
      .QUOT_BITS (SUM_BITS)
   ) u_cell (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cell_ctrl),
      .clk_cells (clk_cells),
      .quotient  (quotient),
      .remainder (remainder),
      .result    (cell_res)
   );

   // Two-entry symbol buffer; filled only when empty
   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign push_end = (state_ff == ST_END) && (cnt_ff == 2'd0);

   always_comb begin
      sym0_in = sym0_ff;
      sym1_in = sym1_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            sym0_in = sym1_ff;
            cnt_in  = 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
      if (cell_ctrl.commit) begin
         sym0_in = cell_res.sym_a;
         sym1_in = cell_res.sym_b;
         cnt_in  = cell_res.two_syms ? 2'd2 : 2'd1;
      end else if (push_end) begin
         sym0_in = mfd_pkg::SYM_END;
         cnt_in  = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      sym0_ff <= sym0_in;
      sym1_ff <= sym1_in;
   end

   assign rsp_ch.valid  = cnt_ff != 2'd0;
   assign rsp_ch.symbol = sym0_ff;
   assign rsp_ch.last   = cnt_ff == 2'd1;

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the MFM flux bit decoder core: intervals in, symbols checked by a local decoder.
module tb_top;

   localparam int IV_BITS       = mfd_pkg::INTERVAL_BITS_DEF;
   localparam int SETTLE_CYCLES = 40;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 190;
   localparam int HOLD_PHASE    = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int A1_CELLS[6]   = '{3, 2, 3, 4, 3, 4};
   localparam int C2_CELLS[6]   = '{2, 3, 4, 3, 4, 3};

   typedef struct {
      logic [IV_BITS-1:0] interval;
      logic               resync;
      logic               block_start;
      logic               end_of_flux;
   } flux_item_type;

   typedef struct packed {
      logic [mfd_pkg::SYM_W-1:0] sym;
      logic                      last;
   } symbol_slot_type;

   typedef struct {
      flux_item_type             item;
      int                        reps;
      bit                        typed;
      logic [mfd_pkg::SYM_W-1:0] sym;
   } stim_row_type;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic rsp_hold  = 1'b0;
   int   stall_pct = 0;
   int   idle_pct  = 0;

   // Decoder state as the block should hold it
   logic [mfd_pkg::CLK_W-1:0]  clock_x2_m;
   logic                       phase_clk_m;
   int                         jitter_m;
   logic [mfd_pkg::HIST_W-1:0] history_m;
   logic [mfd_pkg::RUN_W-1:0]  run_m;
   int unsigned                held_m;
   logic                       held_v_m;

   symbol_slot_type pending_symbols[$];
   flux_item_type   flux_queue[$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int held_items     = 0;
   int clocks_written = 0;
   int symbols_seen   = 0;
   int resync_symbols = 0;
   int bad_symbols    = 0;
   int end_symbols    = 0;

   mfd_req_if #(.INTERVAL_BITS(IV_BITS)) req_ch ();
   mfd_rsp_if                            rsp_ch ();
   mfd_csr_if                            csr_ch ();

   mfm_flux_bit_decoder_core #(.INTERVAL_BITS(IV_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("[mfm_flux_bit_decoder_core] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void clear_decoder();
      phase_clk_m = 1'b0;
      jitter_m    = 0;
      history_m   = '0;
      run_m       = '0;
      held_m      = 0;
      held_v_m    = 1'b0;
   endfunction

   function automatic int unsigned eff_clock();
      return (clock_x2_m < mfd_pkg::CLOCK_X2_MIN) ? mfd_pkg::CLOCK_X2_MIN : clock_x2_m;
   endfunction

   // Symbols one accepted flux item should produce; updates the decoder state
   function automatic void decode_interval(input flux_item_type it,
                                           output logic [1:0][mfd_pkg::SYM_W-1:0] syms,
                                           output int n);
      int unsigned v, clk, quo, rem, guard, cap;
      int d;
      syms = '0;
      n = 0;
      if (it.block_start) clear_decoder();
      if (it.end_of_flux) begin
         held_v_m = 1'b0;
         held_m   = 0;
         syms[0]  = mfd_pkg::SYM_END;
         n        = 1;
         return;
      end
      v   = it.interval;
      clk = eff_clock();

      // short interval is held and added to the next one
      if (held_v_m) begin
         v        = v + held_m;
         held_v_m = 1'b0;
         held_m   = 0;
      end else if (v < clk) begin
         held_m   = v;
         held_v_m = 1'b1;
         return;
      end

      quo = v / clk;
      rem = v % clk;
      if (quo[0]) phase_clk_m = !phase_clk_m;

      // early transition: remainder plus carried jitter beyond the guard band
      guard = phase_clk_m ? (clk * 3) / 5 : (clk * 2) / 5;
      if (int'(rem) + jitter_m > int'(clk - guard)) begin
         quo = quo + 1;
         phase_clk_m = !phase_clk_m;
      end
      d        = int'(v) - int'(quo * clk);
      jitter_m = d / 2;

      // two-cell run tracking while hunting
      if (!it.resync || (quo != 2 && run_m < mfd_pkg::RUN_SYNC)) begin
         run_m = '0;
      end else begin
         if (run_m < mfd_pkg::RUN_MAX) run_m = run_m + 1'b1;
         if (run_m == mfd_pkg::RUN_SYNC && !phase_clk_m) begin
            phase_clk_m = 1'b1;
            syms[0]     = mfd_pkg::SYM_RZERO;
            n           = 1;
            return;
         end
      end

      // sync pattern match on the cell history
      cap       = (quo < 7) ? quo : 7;
      history_m = {history_m[mfd_pkg::HIST_W-4:0], cap[2:0]};
      if ((history_m == mfd_pkg::SYNC_INDEX || history_m == mfd_pkg::SYNC_ID_LONG ||
           history_m[14:0] == mfd_pkg::SYNC_ID_SHORT) && phase_clk_m) begin
         phase_clk_m = 1'b0;
         syms[0]     = mfd_pkg::SYM_RONE;
         n           = 1;
         return;
      end

      case (quo)
         2: begin
            syms[0] = phase_clk_m ? mfd_pkg::SYM_ZERO : mfd_pkg::SYM_ONE;
            n = 1;
         end
         3: begin
            if (!phase_clk_m) begin
               syms[0] = mfd_pkg::SYM_ONE;
               n = 1;
            end else begin
               syms[0] = mfd_pkg::SYM_ZERO;
               syms[1] = mfd_pkg::SYM_ZERO;
               n = 2;
            end
         end
         4: begin
            syms[0] = (phase_clk_m && it.resync) ? mfd_pkg::SYM_MZERO : mfd_pkg::SYM_ZERO;
            syms[1] = phase_clk_m ? mfd_pkg::SYM_ZERO : mfd_pkg::SYM_ONE;
            n = 2;
         end
         default: begin
            syms[0] = mfd_pkg::SYM_BAD;
            n = 1;
         end
      endcase
   endfunction

   function automatic stim_row_type dir_row(input int interval, input int rs, input int bs,
                                            input int eof, input int reps, input int typed,
                                            input logic [mfd_pkg::SYM_W-1:0] sym);
      stim_row_type r;
      r.item.interval    = interval[IV_BITS-1:0];
      r.item.resync      = rs[0];
      r.item.block_start = bs[0];
      r.item.end_of_flux = eof[0];
      r.reps             = reps;
      r.typed            = typed[0];
      r.sym              = sym;
      return r;
   endfunction

   // One flux interval of the given cell count with random jitter
   function automatic flux_item_type mk_cell(input int cells, input logic rs, input int spread);
      flux_item_type it;
      int val;
      val = cells * int'(eff_clock()) + int'($urandom_range(0, 2 * spread)) - spread;
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      it.interval    = val[IV_BITS-1:0];
      it.resync      = rs;
      it.block_start = ($urandom_range(0, 49) == 0);
      it.end_of_flux = 1'b0;
      return it;
   endfunction

   // Queue one random sequence: mostly well-formed MFM, some split, end and noise items
   task automatic queue_random_sequence();
      int roll, n, k, clk, first, second;
      bit c2, broken;
      flux_item_type it;
      clk  = eff_clock();
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         // data cells
         n = $urandom_range(1, 8);
         c2 = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++)
            flux_queue.push_back(mk_cell($urandom_range(2, 4), c2, clk / 4));
      end else if (roll < 72) begin
         // preamble of two-cell intervals, sync marks, then data
         n = $urandom_range(8, 24);
         for (int i = 0; i < n; i++) begin
            it = mk_cell(2, 1'b1, clk / 8);
            if (i == 0) it.block_start = ($urandom_range(0, 3) == 0);
            flux_queue.push_back(it);
         end
         c2     = ($urandom_range(0, 1) == 1);
         broken = ($urandom_range(0, 4) == 0);
         k      = $urandom_range(1, 3);
         for (int r = 0; r < k; r++) begin
            for (int i = 0; i < 6; i++) begin
               it = mk_cell(c2 ? C2_CELLS[i] : A1_CELLS[i], 1'b1, clk / 8);
               if (broken && $urandom_range(0, 5) == 0)
                  it = mk_cell($urandom_range(1, 5), 1'b1, clk / 8);
               flux_queue.push_back(it);
            end
         end
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            flux_queue.push_back(mk_cell($urandom_range(2, 4), 1'b0, clk / 4));
      end else if (roll < 82) begin
         // interval split into a short piece and the rest
         it     = mk_cell($urandom_range(2, 4), ($urandom_range(0, 1) == 1), clk / 4);
         first  = $urandom_range(0, clk - 1);
         second = int'(it.interval) - first;
         if (second < 0) second = 0;
         if ($urandom_range(0, 9) == 0) second = $urandom_range(0, 65535);
         it.interval = first[IV_BITS-1:0];
         flux_queue.push_back(it);
         it.interval    = second[IV_BITS-1:0];
         it.block_start = 1'b0;
         flux_queue.push_back(it);
      end else if (roll < 88) begin
         it.interval    = IV_BITS'($urandom_range(0, 65535));
         it.resync      = ($urandom_range(0, 1) == 1);
         it.block_start = ($urandom_range(0, 1) == 1);
         it.end_of_flux = 1'b1;
         flux_queue.push_back(it);
      end else begin
         it.interval    = ($urandom_range(0, 1) == 1) ? IV_BITS'($urandom_range(0, 65535))
                                                      : IV_BITS'($urandom_range(0, 8 * clk));
         it.resync      = ($urandom_range(0, 1) == 1);
         it.block_start = ($urandom_range(0, 7) == 0);
         it.end_of_flux = 1'b0;
         flux_queue.push_back(it);
      end
   endtask

   // Present one item, with random idle cycles first, until accepted
   task automatic offer_item(input flux_item_type it);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.interval    <= it.interval;
      req_ch.resync      <= it.resync;
      req_ch.block_start <= it.block_start;
      req_ch.end_of_flux <= it.end_of_flux;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic apply_item(input flux_item_type it, input bit typed,
                             input logic [mfd_pkg::SYM_W-1:0] sym);
      logic [1:0][mfd_pkg::SYM_W-1:0] syms;
      int n;
      offer_item(it);
      decode_interval(it, syms, n);
      items_sent++;
      if (n == 0) held_items++;
      if (typed) begin
         pending_symbols.push_back('{sym: sym, last: 1'b1});
      end else begin
         for (int i = 0; i < n; i++)
            pending_symbols.push_back('{sym: syms[i], last: (i == n - 1)});
      end
   endtask

   // Stop offering, wait for every expected symbol, then let the block settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock(input logic [mfd_pkg::CLK_W-1:0] value);
      csr_ch.valid    <= 1'b1;
      csr_ch.clock_x2 <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      clock_x2_m = value;
      clocks_written++;
   endtask

   // Receiver: random stalls plus the long hold-off
   always @(posedge clock) begin
      rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= stall_pct);
   end

   // Symbol checker
   always @(posedge clock) begin : check_symbols
      symbol_slot_type exp_slot;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         symbols_seen++;
         if (rsp_ch.symbol == mfd_pkg::SYM_RZERO || rsp_ch.symbol == mfd_pkg::SYM_RONE)
            resync_symbols++;
         if (rsp_ch.symbol == mfd_pkg::SYM_BAD) bad_symbols++;
         if (rsp_ch.symbol == mfd_pkg::SYM_END) end_symbols++;
         if (pending_symbols.size() == 0) begin
            report_mismatch($sformatf("unexpected symbol %0d last %0b",
                                      rsp_ch.symbol, rsp_ch.last));
         end else begin
            exp_slot = pending_symbols.pop_front();
            if (rsp_ch.symbol !== exp_slot.sym)
               report_mismatch($sformatf("symbol %0d, expected %0d",
                                         rsp_ch.symbol, exp_slot.sym));
            if (rsp_ch.last !== exp_slot.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_ch.last, exp_slot.last));
         end
      end
   end

   initial begin : stimulus
      stim_row_type rows[$];
      int sent;
      // known levels on every input from time zero
      req_ch.valid       = 1'b0;
      req_ch.interval    = '0;
      req_ch.resync      = 1'b0;
      req_ch.block_start = 1'b0;
      req_ch.end_of_flux = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.clock_x2    = mfd_pkg::CLOCK_X2_RESET;
      rsp_ch.ready       = 1'b0;
      clock_x2_m         = mfd_pkg::CLOCK_X2_RESET;
      clear_decoder();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset clock of 48 samples
      rows.push_back(dir_row(0,      0, 1, 1,  1, 1, mfd_pkg::SYM_END));  // end, block start
      rows.push_back(dir_row(96,     0, 1, 0,  1, 0, mfd_pkg::SYM_ZERO));
      rows.push_back(dir_row(144,    0, 0, 0,  1, 0, mfd_pkg::SYM_ZERO));
      rows.push_back(dir_row(192,    1, 0, 0,  1, 0, mfd_pkg::SYM_ZERO)); // four cells, hunting
      rows.push_back(dir_row(0,      0, 0, 0,  1, 0, mfd_pkg::SYM_ZERO)); // shortest, held
      rows.push_back(dir_row(65535,  1, 0, 0,  1, 1, mfd_pkg::SYM_BAD));  // held zero plus max
      rows.push_back(dir_row(47,     0, 0, 0,  1, 0, mfd_pkg::SYM_ZERO)); // held
      rows.push_back(dir_row(65535,  1, 1, 1,  1, 1, mfd_pkg::SYM_END));  // end drops held
      rows.push_back(dir_row(336,    0, 1, 0,  1, 1, mfd_pkg::SYM_BAD));  // seven cells
      rows.push_back(dir_row(70,     0, 0, 0,  1, 0, mfd_pkg::SYM_ZERO));
      rows.push_back(dir_row(96,     1, 0, 0, 16, 0, mfd_pkg::SYM_ZERO)); // sixteen two-cells
      for (int i = 0; i < 6; i++)
         rows.push_back(dir_row(48 * A1_CELLS[i], 1, 0, 0, 1, 0, mfd_pkg::SYM_ZERO));
      rows.push_back(dir_row(100,    0, 0, 0,  1, 0, mfd_pkg::SYM_ZERO));
      foreach (rows[r])
         repeat (rows[r].reps) apply_item(rows[r].item, rows[r].typed, rows[r].sym);
      wait_drained();

      // Random phases over clock settings and idle patterns
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 83; stall_pct <= 0;  write_clock(8'd0);   end
            2: begin idle_pct = 0;  stall_pct <= 83; write_clock(8'd255); end
            3: begin idle_pct = 6;  stall_pct <= 6;  write_clock(mfd_pkg::CLOCK_X2_MIN); end
            4: begin idle_pct = 0;  stall_pct <= 0;  write_clock(8'($urandom_range(5, 254))); end
            5: begin idle_pct = 83; stall_pct <= 83; write_clock(mfd_pkg::CLOCK_X2_RESET); end
            6: begin idle_pct = 0;  stall_pct <= 83; write_clock(8'd3);   end
            default: begin
               idle_pct = 6; stall_pct <= 6; write_clock(8'($urandom_range(4, 120)));
            end
         endcase
         // long receiver hold-off while items keep coming
         if (phase == HOLD_PHASE) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (flux_queue.size() == 0) queue_random_sequence();
            apply_item(flux_queue.pop_front(), 1'b0, mfd_pkg::SYM_ZERO);
            sent++;
         end
         flux_queue.delete();
         wait_drained();
      end

      $display("Covered %0d flux items (%0d held as short) over %0d clock settings.",
               items_sent, held_items, clocks_written + 1);
      $display("Checked %0d symbols: %0d resync, %0d bad, %0d end; %0d mismatches.",
               symbols_seen, resync_symbols, bad_symbols, end_symbols, mismatch_count);
      if (mismatch_count == 0 && pending_symbols.size() == 0) begin
         $display("[mfm_flux_bit_decoder_core] OK");
      end else begin
         $display("[mfm_flux_bit_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
